// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion helpers shared by the pooling block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, disabled during rst
`define MMPS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, disabled during rst
`define MMPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mmps_pkg.sv =====
// ----------------------------------------------------------------------------
// mmps_pkg
// Shared widths, register indexes, mode codes and reset values of the
// streaming max / mean pooling block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmps_pkg;

  localparam int PIXEL_W     = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int WSIZE_W     = 4;
  localparam int DIM_W       = 11;

  typedef logic signed [PIXEL_W-1:0] pixel_t;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_POOL_MODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  // pooling modes
  localparam logic MODE_MAX  = 1'b0;
  localparam logic MODE_MEAN = 1'b1;

  // register reset values
  localparam logic               RST_POOL_MODE    = MODE_MAX;
  localparam logic [WSIZE_W-1:0] RST_WINDOW_SIZE  = 4'd2;
  localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 11'd64;
  localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 11'd64;

endpackage

// ===== src/max_mean_pooling_stream.sv =====
// ----------------------------------------------------------------------------
// max_mean_pooling_stream
// Non-overlapping square max / mean pooling over raster-ordered planes.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on in_valid / in_ready, one signed Q8.8 sample per transfer,
//   in raster order; after image_height rows the next plane starts. Each
//   window_size x window_size window (stride = window) gives one result on
//   out_valid / out_ready: max with in-window position, or truncated mean.
//   Partial edge windows give nothing.
//   Per-column accumulators live in one synchronous RAM of MAX_WIDTH words;
//   every pixel does one read-modify-write of its window column entry, with
//   a forwarding register covering back-to-back pixels of the same window.
//   Throughput: one pixel per cycle while the receiver keeps up. A result
//   passes the update stage (RAM read with the update) and then the divide
//   stage (reciprocal multiply for the mean) into the result register.
//   A stalled receiver holds the result register; the stage behind it keeps
//   one more result, after which the update stage and in_ready stall.
//   Reset (rst, synchronous) sets the registers to their defaults and
//   restarts the plane; the RAM needs no clearing since each window
//   overwrites its entry on its first pixel. A register write restarts the
//   plane as well and must only happen while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module max_mean_pooling_stream #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [mmps_pkg::PIXEL_W-1:0]    pixel_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [mmps_pkg::PIXEL_W-1:0]    pooled_value,
  output logic [2*$clog2(MAX_WINDOW)-1:0]        max_position,
  output logic [$clog2(MAX_WIDTH)-1:0]           out_column,
  output logic [$clog2(MAX_WIDTH)-1:0]           out_row,
  output logic                                   plane_done,
  input  logic                                   cfg_write,
  input  logic [mmps_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [mmps_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int PIXEL_W = mmps_pkg::PIXEL_W;
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int WL      = $clog2(MAX_WINDOW);
  localparam int PSW     = 2 * WL;
  localparam int KW      = $clog2(MAX_WINDOW + 1);
  localparam int DW      = $clog2(MAX_WIDTH + 1);
  localparam int EW      = $clog2(MAX_WIDTH + 2 * MAX_WINDOW + 1);
  localparam int SUM_W   = PIXEL_W + 2 * WL;
  localparam int SHIFT   = SUM_W + 2 * WL;
  localparam int RW      = SHIFT + 1;
  localparam int PW      = SUM_W + RW;

  typedef struct packed {
    logic signed [PIXEL_W-1:0] best;
    logic [PSW-1:0]            pos;
    logic signed [SUM_W-1:0]   sum;
  } acc_t;

  // configuration
  logic                          pool_mode;
  logic [mmps_pkg::WSIZE_W-1:0]  window_size;
  logic [mmps_pkg::DIM_W-1:0]    image_width;
  logic [mmps_pkg::DIM_W-1:0]    image_height;
  logic                          cfg_known;

  logic [KW-1:0] k;
  logic [DW-1:0] w;
  logic [DW-1:0] h;
  logic [EW-1:0] k_e;

  // position counters
  logic [CW-1:0] col_cnt, col_cnt_next;
  logic [CW-1:0] row_cnt, row_cnt_next;
  logic [WL-1:0] cx, cx_next;
  logic [WL-1:0] cy, cy_next;
  logic [CW-1:0] win_col, win_col_next;
  logic [CW-1:0] orow, orow_next;
  logic [EW-1:0] col_base, col_base_next;
  logic [EW-1:0] row_base, row_base_next;

  logic           in_fire;
  logic           win_active;
  logic           win_first;
  logic           win_last;
  logic           win_done;
  logic [PSW-1:0] win_pos;
  logic [EW-1:0]  col_end;
  logic [EW-1:0]  row_end;

  // accumulator ram
  acc_t mem [MAX_WIDTH];
  acc_t rd_word;
  acc_t fwd_word;
  acc_t acc_base;
  acc_t acc_new;
  logic [SUM_W-1:0] sum_abs;

  // update stage
  logic                s1_valid;
  logic signed [PIXEL_W-1:0] s1_pix;
  logic [CW-1:0]       s1_idx;
  logic                s1_active;
  logic                s1_first;
  logic                s1_last;
  logic [PSW-1:0]      s1_pos;
  logic [CW-1:0]       s1_row;
  logic                s1_done;
  logic                s1_fwd;
  logic                s1_emit;
  logic                s1_fire;

  // divide stage
  logic                      s2_valid;
  logic signed [PIXEL_W-1:0] s2_max;
  logic [PSW-1:0]            s2_pos;
  logic [SUM_W-1:0]          s2_abs;
  logic                      s2_neg;
  logic [CW-1:0]             s2_col;
  logic [CW-1:0]             s2_row;
  logic                      s2_done;
  logic                      s2_go;

  logic [RW-1:0]      recip [MAX_WINDOW+1];
  logic [PW-1:0]      prod;
  logic [PIXEL_W-1:0] mean_q;
  logic [PIXEL_W-1:0] mean_val;

  // reciprocal of k*k, rounded up, exact for every sum magnitude
  for (genvar g = 0; g <= MAX_WINDOW; g++) begin : g_recip
    localparam longint unsigned DIV = (g == 0) ? 1 : g * g;
    localparam longint unsigned ONE = 64'd1 << SHIFT;
    assign recip[g] = RW'((ONE + DIV - 1) / DIV);
  end

  // clamped geometry
  always_comb begin
    if (window_size == '0) begin
      k = KW'(1);
    end else if (int'(window_size) > MAX_WINDOW) begin
      k = KW'(MAX_WINDOW);
    end else begin
      k = KW'(window_size);
    end
    if (image_width == '0) begin
      w = DW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w = DW'(MAX_WIDTH);
    end else begin
      w = DW'(image_width);
    end
    if (image_height == '0) begin
      h = DW'(1);
    end else if (int'(image_height) > MAX_WIDTH) begin
      h = DW'(MAX_WIDTH);
    end else begin
      h = DW'(image_height);
    end
  end

  assign k_e = EW'(k);

  always_comb begin
    case (cfg_index)
      mmps_pkg::REG_POOL_MODE,
      mmps_pkg::REG_WINDOW_SIZE,
      mmps_pkg::REG_IMAGE_WIDTH,
      mmps_pkg::REG_IMAGE_HEIGHT: cfg_known = 1'b1;
      default:                    cfg_known = 1'b0;
    endcase
  end

  // window of the incoming pixel: full windows only
  assign col_end    = col_base + k_e;
  assign row_end    = row_base + k_e;
  assign win_active = (col_end <= EW'(w)) && (row_end <= EW'(h));
  assign win_done   = ((col_end + k_e) > EW'(w)) && ((row_end + k_e) > EW'(h));
  assign win_first  = (cx == '0) && (cy == '0);
  assign win_last   = (KW'(cx) == k - KW'(1)) && (KW'(cy) == k - KW'(1));
  assign win_pos    = PSW'(cx) + PSW'(PSW'(cy) * PSW'(k));

  assign in_fire = in_valid && in_ready;

  always_comb begin
    col_cnt_next  = col_cnt;
    row_cnt_next  = row_cnt;
    cx_next       = cx;
    cy_next       = cy;
    win_col_next  = win_col;
    orow_next     = orow;
    col_base_next = col_base;
    row_base_next = row_base;
    if (cfg_write && cfg_known) begin
      col_cnt_next  = '0;
      row_cnt_next  = '0;
      cx_next       = '0;
      cy_next       = '0;
      win_col_next  = '0;
      orow_next     = '0;
      col_base_next = '0;
      row_base_next = '0;
    end else if (in_fire) begin
      if (KW'(cx) + KW'(1) >= k) begin
        cx_next       = '0;
        win_col_next  = win_col + CW'(1);
        col_base_next = col_base + k_e;
      end else begin
        cx_next = cx + WL'(1);
      end
      if (DW'(col_cnt) + DW'(1) >= w) begin
        // end of row
        col_cnt_next  = '0;
        cx_next       = '0;
        win_col_next  = '0;
        col_base_next = '0;
        if (KW'(cy) + KW'(1) >= k) begin
          cy_next       = '0;
          orow_next     = orow + CW'(1);
          row_base_next = row_base + k_e;
        end else begin
          cy_next = cy + WL'(1);
        end
        if (DW'(row_cnt) + DW'(1) >= h) begin
          // end of plane
          row_cnt_next  = '0;
          cy_next       = '0;
          orow_next     = '0;
          row_base_next = '0;
        end else begin
          row_cnt_next = row_cnt + CW'(1);
        end
      end else begin
        col_cnt_next = col_cnt + CW'(1);
      end
    end
  end

  // read-modify-write of the window column entry
  always_comb begin
    if (s1_first) begin
      acc_base = '0;
    end else if (s1_fwd) begin
      acc_base = fwd_word;
    end else begin
      acc_base = rd_word;
    end
    acc_new = acc_base;
    if (s1_pix > acc_base.best) begin
      acc_new.best = s1_pix;
      acc_new.pos  = s1_pos;
    end
    acc_new.sum = acc_base.sum + SUM_W'(s1_pix);
    sum_abs = acc_new.sum[SUM_W-1] ? SUM_W'(-acc_new.sum) : SUM_W'(acc_new.sum);
  end

  assign s2_go    = s2_valid && (!out_valid || out_ready);
  assign s1_emit  = s1_active && s1_last;
  assign s1_fire  = s1_valid && (!s1_emit || !s2_valid || s2_go);
  assign in_ready = !s1_valid || s1_fire;

  // mean by reciprocal multiply, sign restored afterwards
  assign prod     = PW'(s2_abs) * PW'(recip[k]);
  assign mean_q   = prod[SHIFT +: PIXEL_W];
  assign mean_val = s2_neg ? -mean_q : mean_q;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_word <= mem[win_col];
    end
    if (s1_fire && s1_active) begin
      mem[s1_idx] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_mode    <= mmps_pkg::RST_POOL_MODE;
      window_size  <= mmps_pkg::RST_WINDOW_SIZE;
      image_width  <= mmps_pkg::RST_IMAGE_WIDTH;
      image_height <= mmps_pkg::RST_IMAGE_HEIGHT;
      col_cnt      <= '0;
      row_cnt      <= '0;
      cx           <= '0;
      cy           <= '0;
      win_col      <= '0;
      orow         <= '0;
      col_base     <= '0;
      row_base     <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          mmps_pkg::REG_POOL_MODE:    pool_mode    <= cfg_data[0];
          mmps_pkg::REG_WINDOW_SIZE:  window_size  <= cfg_data[mmps_pkg::WSIZE_W-1:0];
          mmps_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[mmps_pkg::DIM_W-1:0];
          mmps_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[mmps_pkg::DIM_W-1:0];
          default: ;
        endcase
      end
      col_cnt  <= col_cnt_next;
      row_cnt  <= row_cnt_next;
      cx       <= cx_next;
      cy       <= cy_next;
      win_col  <= win_col_next;
      orow     <= orow_next;
      col_base <= col_base_next;
      row_base <= row_base_next;
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire && s1_emit) begin
        s2_valid <= 1'b1;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
      if (s2_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix    <= pixel_value;
      s1_idx    <= win_col;
      s1_active <= win_active;
      s1_first  <= win_first;
      s1_last   <= win_last;
      s1_pos    <= win_pos;
      s1_row    <= orow;
      s1_done   <= win_done;
      // entry written at this very edge: ram read returns the old word
      s1_fwd    <= s1_fire && s1_active && (s1_idx == win_col);
    end
    if (s1_fire) begin
      fwd_word <= acc_new;
    end
    if (s1_fire && s1_emit) begin
      s2_max  <= acc_new.best;
      s2_pos  <= (pool_mode == mmps_pkg::MODE_MAX) ? acc_new.pos : '0;
      s2_abs  <= sum_abs;
      s2_neg  <= acc_new.sum[SUM_W-1];
      s2_col  <= s1_idx;
      s2_row  <= s1_row;
      s2_done <= s1_done;
    end
    if (s2_go) begin
      pooled_value <= (pool_mode == mmps_pkg::MODE_MEAN) ? mmps_pkg::pixel_t'(mean_val)
                                                         : s2_max;
      max_position <= s2_pos;
      out_column   <= s2_col;
      out_row      <= s2_row;
      plane_done   <= s2_done;
    end
  end

  `MMPS_ASSERT(a_stall_blocks_input, s1_valid && !s1_fire, !in_ready, "input taken while update stage stalled")
  `MMPS_ASSERT(a_window_counters, 1'b1, (KW'(cx) < k) && (KW'(cy) < k), "window position beyond window size")
  `MMPS_ASSERT_NEXT(a_result_kept, s2_valid && out_valid && !out_ready, s2_valid, "pending result dropped during stall")
  `MMPS_ASSERT(a_max_nonneg, s2_valid, !s2_max[PIXEL_W-1], "window max below zero")

endmodule

// ===== tb/sv/tb_max_mean_pooling_stream.sv =====
// ----------------------------------------------------------------------------
// tb_max_mean_pooling_stream
// Streams raster pixels through the pooling block under several register
// settings. A predictor tracks the per-column window state and the plane
// counters, and queues the expected window result. Each output transfer
// is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_max_mean_pooling_stream;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_WINDOW    = 8;
  localparam int POS_W         = 2 * $clog2(MAX_WINDOW);
  localparam int COORD_W       = $clog2(MAX_WIDTH);
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    mmps_pkg::pixel_t     value;
    logic [POS_W-1:0]     position;
    logic [COORD_W-1:0]   column;
    logic [COORD_W-1:0]   row;
    logic                 plane_end;
  } window_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  mmps_pkg::pixel_t                 pixel_value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  mmps_pkg::pixel_t                 pooled_value;
  logic [POS_W-1:0]                 max_position;
  logic [COORD_W-1:0]               out_column;
  logic [COORD_W-1:0]               out_row;
  logic                             plane_done;
  logic                             cfg_write = 1'b0;
  logic [mmps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mmps_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;

  window_result_t expected_windows[$];

  // predictor copy of the registers and the plane position
  logic                         mode_q   = mmps_pkg::RST_POOL_MODE;
  logic [mmps_pkg::WSIZE_W-1:0] wsize_q  = mmps_pkg::RST_WINDOW_SIZE;
  logic [mmps_pkg::DIM_W-1:0]   width_q  = mmps_pkg::RST_IMAGE_WIDTH;
  logic [mmps_pkg::DIM_W-1:0]   height_q = mmps_pkg::RST_IMAGE_HEIGHT;
  int col_count = 0;
  int row_count = 0;
  int col_in_win = 0;
  int row_in_win = 0;
  int win_col = 0;
  int win_max[MAX_WIDTH];
  int win_max_pos[MAX_WIDTH];
  int win_sum[MAX_WIDTH];

  max_mean_pooling_stream #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_WINDOW(MAX_WINDOW)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_value (pixel_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pooled_value(pooled_value),
    .max_position(max_position),
    .out_column  (out_column),
    .out_row     (out_row),
    .plane_done  (plane_done),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_max_mean_pooling_stream failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic int clamp_dim(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_plane();
    col_count = 0;
    row_count = 0;
    col_in_win = 0;
    row_in_win = 0;
    win_col = 0;
  endfunction

  function automatic void load_register(input logic [mmps_pkg::CFG_INDEX_W-1:0] idx,
                                        input logic [mmps_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      mmps_pkg::REG_POOL_MODE:    mode_q = data[0];
      mmps_pkg::REG_WINDOW_SIZE:  wsize_q = data[mmps_pkg::WSIZE_W-1:0];
      mmps_pkg::REG_IMAGE_WIDTH:  width_q = data[mmps_pkg::DIM_W-1:0];
      mmps_pkg::REG_IMAGE_HEIGHT: height_q = data[mmps_pkg::DIM_W-1:0];
      default: ;
    endcase
    restart_plane();
  endfunction

  // accumulate one pixel into its window column, queue the result on the
  // last pixel of a full window
  function automatic void pool_pixel(input mmps_pkg::pixel_t v);
    int k, w, h, ow, oh, orow, i;
    window_result_t r;
    k = clamp_dim(wsize_q, MAX_WINDOW);
    w = clamp_dim(width_q, MAX_WIDTH);
    h = clamp_dim(height_q, MAX_WIDTH);
    ow = w / k;
    oh = h / k;
    orow = row_count / k;
    if (win_col < ow && orow < oh) begin
      i = win_col;
      if (col_in_win == 0 && row_in_win == 0) begin
        win_max[i] = 0;
        win_max_pos[i] = 0;
        win_sum[i] = 0;
      end
      // strictly greater only, so ties keep the first position
      if (v > win_max[i]) begin
        win_max[i] = v;
        win_max_pos[i] = col_in_win + row_in_win * k;
      end
      win_sum[i] += v;
      if (col_in_win == k - 1 && row_in_win == k - 1) begin
        if (mode_q == mmps_pkg::MODE_MAX) begin
          r.value = mmps_pkg::pixel_t'(win_max[i]);
          r.position = POS_W'(win_max_pos[i]);
        end else begin
          r.value = mmps_pkg::pixel_t'(win_sum[i] / (k * k));
          r.position = '0;
        end
        r.column = COORD_W'(i);
        r.row = COORD_W'(orow);
        r.plane_end = (i == ow - 1 && orow == oh - 1);
        expected_windows.push_back(r);
      end
    end
    col_in_win++;
    if (col_in_win >= k) begin
      col_in_win = 0;
      win_col++;
    end
    col_count++;
    if (col_count >= w) begin
      col_count = 0;
      col_in_win = 0;
      win_col = 0;
      row_in_win++;
      if (row_in_win >= k) row_in_win = 0;
      row_count++;
      if (row_count >= h) begin
        row_count = 0;
        row_in_win = 0;
      end
    end
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    window_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_windows.size() == 0) begin
        $error("unexpected result: pooled_value %0d column %0d row %0d",
               pooled_value, out_column, out_row);
        mismatches++;
      end else begin
        want = expected_windows.pop_front();
        check_field("pooled_value", want.value, pooled_value);
        check_field("max_position", want.position, max_position);
        check_field("out_column", want.column, out_column);
        check_field("out_row", want.row, out_row);
        check_field("plane_done", want.plane_end, plane_done);
      end
    end
  end

  // valid is only dropped when an idle cycle is actually inserted
  task automatic send_pixel(input mmps_pkg::pixel_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_value <= v;
    do @(posedge clk); while (!in_ready);
    pool_pixel(v);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all four registers back to back; block must be idle
  task automatic write_config(input logic [mmps_pkg::CFG_DATA_W-1:0] mode,
                              input logic [mmps_pkg::CFG_DATA_W-1:0] wsize,
                              input logic [mmps_pkg::CFG_DATA_W-1:0] width,
                              input logic [mmps_pkg::CFG_DATA_W-1:0] height);
    logic [mmps_pkg::CFG_INDEX_W-1:0] regs[4];
    logic [mmps_pkg::CFG_DATA_W-1:0] data[4];
    regs = '{mmps_pkg::REG_POOL_MODE, mmps_pkg::REG_WINDOW_SIZE,
             mmps_pkg::REG_IMAGE_WIDTH, mmps_pkg::REG_IMAGE_HEIGHT};
    data = '{mode, wsize, width, height};
    wait_for_results();
    for (int j = 0; j < 4; j++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[j];
      cfg_data <= data[j];
      @(posedge clk);
      load_register(regs[j], data[j]);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic mmps_pkg::pixel_t random_pixel();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return mmps_pkg::pixel_t'($urandom);
    if (pick < 70) return mmps_pkg::pixel_t'(int'($urandom_range(0, 16)) - 8);
    if (pick < 85) begin
      case ($urandom_range(0, 3))
        0: return mmps_pkg::pixel_t'(32767);
        1: return mmps_pkg::pixel_t'(-32768);
        2: return mmps_pkg::pixel_t'(0);
        default: return mmps_pkg::pixel_t'(-1);
      endcase
    end
    return mmps_pkg::pixel_t'(-int'($urandom_range(1, 32768)));
  endfunction

  // no register write yet: 64-wide plane, 2x2 max windows
  task automatic test_reset_defaults();
    repeat (128) send_pixel(random_pixel());
  endtask

  task automatic test_max_ties_and_negatives();
    mmps_pkg::pixel_t seq[16];
    // plane 1: all-negative window, then a tie of 9 that keeps its first spot
    // plane 2: full-scale max in the last spot, then all full-scale negative
    seq = '{-1, -32768, 3, 9, -5, -2, 9, 1,
            0, 0, -32768, -32768, 0, 32767, -32768, -32768};
    write_config(mmps_pkg::MODE_MAX, 2, 4, 2);
    foreach (seq[j]) send_pixel(seq[j]);
  endtask

  task automatic test_mean_truncation();
    mmps_pkg::pixel_t seq[20];
    seq = '{32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768,
            -1, 0, 0, 0, 1, 1, 1, 0, -3, -3, -3, 0};
    write_config(mmps_pkg::MODE_MEAN, 2, 2, 2);
    foreach (seq[j]) send_pixel(seq[j]);
  endtask

  // window sizes above the limit clamp to the largest window
  task automatic test_window_saturation();
    write_config(mmps_pkg::MODE_MAX, 15, 8, 8);
    for (int j = 0; j < 64; j++) send_pixel(mmps_pkg::pixel_t'(j * 100 - 3000));
    write_config(mmps_pkg::MODE_MEAN, 9, 8, 8);
    repeat (64) send_pixel(mmps_pkg::pixel_t'(-32768));
  endtask

  task automatic test_partial_edges();
    write_config(mmps_pkg::MODE_MEAN, 3, 7, 7);
    repeat (49) send_pixel(random_pixel());
    // plane narrower than the window gives nothing
    write_config(mmps_pkg::MODE_MAX, 4, 3, 5);
    repeat (30) send_pixel(random_pixel());
  endtask

  // zero sizes act as one; only the low bits of each register count
  task automatic test_zero_sizes();
    write_config(11'h7FF, 11'h7F0, 0, 0);
    send_pixel(mmps_pkg::pixel_t'(32767));
    send_pixel(mmps_pkg::pixel_t'(-32768));
    send_pixel(mmps_pkg::pixel_t'(-1));
    write_config(11'h7FE, 11'h7F1, 0, 0);
    send_pixel(mmps_pkg::pixel_t'(-1));
    send_pixel(mmps_pkg::pixel_t'(5));
  endtask

  // oversized width and height clamp to the widest plane
  task automatic test_large_planes();
    write_config(mmps_pkg::MODE_MAX, 1, 11'h7FF, 1);
    repeat (24) send_pixel(random_pixel());
    write_config(mmps_pkg::MODE_MEAN, 1, 1, 11'h7FF);
    repeat (24) send_pixel(random_pixel());
  endtask

  task automatic test_random_planes(input int send_pct, input int recv_pct,
                                    input int item_goal);
    int sent, n, k, plane, pick;
    logic [mmps_pkg::CFG_DATA_W-1:0] wsize, width, height;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < item_goal) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) wsize = '0;
      else if (pick == 1) wsize = mmps_pkg::CFG_DATA_W'($urandom_range(9, 15));
      else wsize = mmps_pkg::CFG_DATA_W'($urandom_range(1, (pick < 6) ? MAX_WINDOW : 4));
      k = clamp_dim(wsize, MAX_WINDOW);
      if ($urandom_range(0, 19) == 0) begin
        width = mmps_pkg::CFG_DATA_W'($urandom_range(0, 2047));
        height = mmps_pkg::CFG_DATA_W'($urandom_range(0, 2047));
        n = $urandom_range(8, 64);
      end else begin
        // mostly whole windows, sometimes with a ragged right or bottom edge
        width = mmps_pkg::CFG_DATA_W'(k * $urandom_range(1, (8 / k > 1) ? 8 / k : 1)
                + (($urandom_range(0, 2) == 0) ? $urandom_range(0, k - 1) : 0));
        height = mmps_pkg::CFG_DATA_W'(k * $urandom_range(1, (4 / k > 1) ? 4 / k : 1)
                 + (($urandom_range(0, 2) == 0) ? $urandom_range(0, k - 1) : 0));
        plane = width * height;
        n = $urandom_range(plane / 2, plane + plane / 2) + 1;
      end
      if (n > item_goal - sent) n = item_goal - sent;
      write_config(mmps_pkg::CFG_DATA_W'($urandom_range(0, 1)), wsize, width, height);
      for (int j = 0; j < n; j++) begin
        if (j == n / 2 && $urandom_range(0, 3) == 0) wait_for_results();
        send_pixel(random_pixel());
      end
      sent += n;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 60;
    test_reset_defaults();
    test_max_ties_and_negatives();
    test_mean_truncation();
    test_window_saturation();
    test_partial_edges();
    test_zero_sizes();
    test_large_planes();
    test_random_planes(23, 60, 60);
    test_random_planes(60, 23, 60);
    test_random_planes(0, 0, 60);
    wait_for_results();
    if (mismatches == 0) begin
      $display("tb_max_mean_pooling_stream passed");
    end else begin
      $display("tb_max_mean_pooling_stream failed");
    end
    $finish;
  end

endmodule
